// File: rtl/core/clc_pkg.sv
// Shared types and constants for the coefficient level context block.
// Used by the front, store, job queue and back modules; no dependencies.
package clc_pkg;

	localparam int LVL_W      = 4;
	localparam int ROW_LANES  = 8;
	localparam int ROW_W      = LVL_W * ROW_LANES;
	localparam int WORD_AW    = 3;
	localparam int STORE_AW   = WORD_AW + 1;
	localparam int STORE_ROWS = 1 << STORE_AW;
	localparam int JOB_DEPTH  = 2;
	localparam int JOB_PW     = $clog2(JOB_DEPTH);
	localparam int TOTAL_W    = 6;
	localparam int COEF_W     = 16;
	localparam int OUT_W      = 32;

	// One finished grid waiting for emission
	typedef struct packed {
		logic               bank;
		logic               is8;
		logic [TOTAL_W-1:0] total;
	} job_t;

	// Back reports that a bank has been fully read out
	typedef struct packed {
		logic valid;
		logic bank;
	} done_t;

	// Nibble write into the level store
	typedef struct packed {
		logic               en;
		logic               bank;
		logic [WORD_AW-1:0] word;
		logic [2:0]         lane;
		logic [LVL_W-1:0]   level;
	} wr_req_t;

	// Row word read from the level store
	typedef struct packed {
		logic               en;
		logic               bank;
		logic [WORD_AW-1:0] word;
	} rd_req_t;

endpackage

// File: rtl/core/clc_store.sv
// Two-bank level store: 8 row words of 8 nibbles per bank.
// Nibble write port, one registered row read port. Depends on clc_pkg.
module clc_store import clc_pkg::*; (
	input  logic             clk,
	input  wr_req_t          wr,
	input  rd_req_t          rd,
	output logic [ROW_W-1:0] rdata
);

	logic [ROW_W-1:0] mem [STORE_ROWS];
	logic [ROW_W-1:0] rdata_q;

	// Write one level nibble
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr.bank, wr.word}][{wr.lane, 2'b00} +: LVL_W] <= wr.level;
		end
	end

	// Read one row word, hold when not reading
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata_q <= mem[{rd.bank, rd.word}];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/clc_job_fifo.sv
// Short queue of finished grids between the front and the back.
// Depends on clc_pkg.
module clc_job_fifo import clc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic not_empty
);

	job_t                slot_q [JOB_DEPTH];
	logic [JOB_PW-1:0]   wptr_q;
	logic [JOB_PW-1:0]   rptr_q;
	logic [JOB_PW:0]     fill_q;

	// Store pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign pop_job   = slot_q[rptr_q];
	assign not_empty = (fill_q != '0);

endmodule

// File: rtl/core/clc_front.sv
// Front end: accepts coefficients, clamps them, writes levels and sums magnitudes.
// Hands each completed grid to the job queue. Depends on clc_pkg.
module clc_front import clc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [1:0]        cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [COEF_W-1:0] s_tdata,
	output wr_req_t           wr,
	output logic              push,
	output job_t              push_job,
	input  done_t             done
);

	logic [1:0]         block_size_q;
	logic [6:0]         cnt_q;
	logic [TOTAL_W-1:0] sum_q;
	logic               wbank_q;
	logic [1:0]         busy_q;

	logic               accept;
	logic               is8;
	logic [7:0]         mag;
	logic [LVL_W-1:0]   level;
	logic [8:0]         sum_wide;
	logic [TOTAL_W-1:0] sum_next;
	logic [6:0]         cnt_next;
	logic               grid_full;
	logic [1:0]         busy_next;

	assign is8      = (block_size_q != 2'd0);
	assign s_tready = !busy_q[wbank_q];
	assign accept   = s_tvalid && s_tready;

	// Clamp to -128..127 and take magnitude
	always_comb begin
		if (s_tdata[COEF_W-1]) begin
			if (s_tdata[COEF_W-1:7] == '1) begin
				mag = 8'(-s_tdata);
			end else begin
				mag = 8'd128;
			end
		end else begin
			if (s_tdata[COEF_W-2:7] != '0) begin
				mag = 8'd127;
			end else begin
				mag = {1'b0, s_tdata[6:0]};
			end
		end
	end

	assign level    = (mag > 8'd15) ? 4'd15 : mag[LVL_W-1:0];
	assign sum_wide = {3'b000, sum_q} + {1'b0, mag};
	assign sum_next = (sum_wide > 9'd63) ? 6'd63 : sum_wide[TOTAL_W-1:0];
	assign cnt_next = cnt_q + 7'd1;
	assign grid_full = is8 ? (cnt_next >= 7'd64) : (cnt_next >= 7'd16);

	// Store write request
	always_comb begin
		wr.en    = accept;
		wr.bank  = wbank_q;
		wr.word  = cnt_q[5:3];
		wr.lane  = cnt_q[2:0];
		wr.level = level;
	end

	// Job for a completed grid
	assign push           = accept && grid_full;
	assign push_job.bank  = wbank_q;
	assign push_job.is8   = is8;
	assign push_job.total = sum_next;

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= 2'd0;
		end else if (cfg_wen) begin
			block_size_q <= cfg_wdata;
		end
	end

	// Advance count and sum, swap banks at grid end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			wbank_q <= 1'b0;
		end else if (accept) begin
			if (grid_full) begin
				cnt_q   <= '0;
				sum_q   <= '0;
				wbank_q <= !wbank_q;
			end else begin
				cnt_q <= cnt_next;
				sum_q <= sum_next;
			end
		end
	end

	// Mark the filled bank busy, release the bank the back has read out
	always_comb begin
		busy_next = busy_q;
		if (push) begin
			busy_next[wbank_q] = 1'b1;
		end
		if (done.valid) begin
			busy_next[done.bank] = 1'b0;
		end
	end

	// Track banks that hold grids not yet emitted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			busy_q <= busy_next;
		end
	end

endmodule

// File: rtl/core/clc_back.sv
// Back end: walks a stored grid in raster order with a three-row window
// and computes level, base and range contexts. Depends on clc_pkg.
module clc_back import clc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_ready,
	input  job_t              job_in,
	output logic              pop,
	output rd_req_t           rd,
	input  logic [ROW_W-1:0]  rdata,
	output done_t             done,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,
	output logic              m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	localparam logic [3:0] BASE_OFFSET [8] = '{
		4'd0, 4'd1, 4'd6, 4'd6, 4'd11, 4'd11, 4'd11, 4'd11
	};

	state_t           state_q;
	job_t             job_q;
	logic [2:0]       row_q;
	logic [2:0]       col_q;
	logic [1:0]       ld_q;
	logic [ROW_W-1:0] win0_q;
	logic [ROW_W-1:0] win1_q;
	logic [ROW_W-1:0] win2_q;
	logic             rd_half_q;
	logic             rd_zero_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             out_last_q;

	logic [3:0]       rd_row;
	logic [ROW_W-1:0] fetched;
	logic             advance;
	logic [2:0]       side_m1;
	logic             row_end;
	logic             grid_end;

	logic [3:0]       c1;
	logic [3:0]       c2;
	logic [LVL_W-1:0] lv_self;
	logic [LVL_W-1:0] lv_right;
	logic [LVL_W-1:0] lv_right2;
	logic [LVL_W-1:0] lv_below;
	logic [LVL_W-1:0] lv_diag;
	logic [LVL_W-1:0] lv_below2;
	logic [3:0]       bsum;
	logic [4:0]       bhalf;
	logic [2:0]       bcap;
	logic [3:0]       boff;
	logic [LVL_W-1:0] bctx;
	logic [5:0]       rsum;
	logic [4:0]       rhalf;
	logic [2:0]       rcap;
	logic [4:0]       roff;
	logic [4:0]       range_ctx;
	logic [3:0]       diag;
	logic [5:0]       position;

	function automatic logic [LVL_W-1:0] lane_at(logic [ROW_W-1:0] w, logic [3:0] idx);
		logic [LVL_W-1:0] v;
		v = idx[3] ? '0 : w[{idx[2:0], 2'b00} +: LVL_W];
		return v;
	endfunction

	function automatic logic [1:0] cap3(logic [LVL_W-1:0] v);
		logic [1:0] c;
		c = (v > 4'd3) ? 2'd3 : v[1:0];
		return c;
	endfunction

	assign side_m1  = job_q.is8 ? 3'd7 : 3'd3;
	assign row_end  = (col_q == side_m1);
	assign grid_end = row_end && (row_q == side_m1);
	assign advance  = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	assign pop      = (state_q == ST_IDLE) && job_ready;

	// Pick the row to fetch: preload rows, then the row three ahead
	assign rd_row = (state_q == ST_LOAD) ? {2'b00, ld_q} : ({1'b0, row_q} + 4'd3);

	always_comb begin
		rd.en   = ((state_q == ST_LOAD) && (ld_q != 2'd3))
		       || ((state_q == ST_EMIT) && (col_q == 3'd0));
		rd.bank = job_q.bank;
		rd.word = job_q.is8 ? rd_row[2:0] : {1'b0, rd_row[2:1]};
	end

	// Unpack fetched word into an 8-lane row, zero outside the grid
	always_comb begin
		if (rd_zero_q) begin
			fetched = '0;
		end else if (job_q.is8) begin
			fetched = rdata;
		end else if (rd_half_q) begin
			fetched = {{(ROW_W/2){1'b0}}, rdata[ROW_W-1:ROW_W/2]};
		end else begin
			fetched = {{(ROW_W/2){1'b0}}, rdata[ROW_W/2-1:0]};
		end
	end

	// Neighbor levels
	assign c1        = {1'b0, col_q} + 4'd1;
	assign c2        = {1'b0, col_q} + 4'd2;
	assign lv_self   = lane_at(win0_q, {1'b0, col_q});
	assign lv_right  = lane_at(win0_q, c1);
	assign lv_right2 = lane_at(win0_q, c2);
	assign lv_below  = lane_at(win1_q, {1'b0, col_q});
	assign lv_diag   = lane_at(win1_q, c1);
	assign lv_below2 = lane_at(win2_q, {1'b0, col_q});

	// Base context
	assign bsum  = {2'b00, cap3(lv_right)} + {2'b00, cap3(lv_below)} + {2'b00, cap3(lv_diag)}
	             + {2'b00, cap3(lv_right2)} + {2'b00, cap3(lv_below2)};
	assign bhalf = ({1'b0, bsum} + 5'd1) >> 1;
	assign bcap  = (bhalf > 5'd4) ? 3'd4 : bhalf[2:0];
	assign diag  = {1'b0, row_q} + {1'b0, col_q};
	assign boff  = (diag > 4'd7) ? BASE_OFFSET[7] : BASE_OFFSET[diag[2:0]];
	assign bctx  = 4'({1'b0, bcap} + boff);

	// Range context
	assign rsum  = {2'b00, lv_right} + {2'b00, lv_below} + {2'b00, lv_diag};
	assign rhalf = 5'(({1'b0, rsum} + 7'd1) >> 1);
	assign rcap  = (rhalf > 5'd6) ? 3'd6 : rhalf[2:0];
	always_comb begin
		if (diag == 4'd0) begin
			roff = 5'd0;
		end else if ((row_q < 3'd2) && (col_q < 3'd2)) begin
			roff = 5'd7;
		end else begin
			roff = 5'd14;
		end
	end
	assign range_ctx = {2'b00, rcap} + roff;

	assign position = job_q.is8 ? {row_q, col_q} : {2'b00, row_q[1:0], col_q[1:0]};

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ld_q    <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_ready) begin
						ld_q    <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					ld_q <= ld_q + 2'd1;
					if (ld_q == 2'd3) begin
						row_q   <= '0;
						col_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (advance) begin
						if (grid_end) begin
							state_q <= ST_IDLE;
						end else if (row_end) begin
							row_q <= row_q + 3'd1;
							col_q <= '0;
						end else begin
							col_q <= col_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch job, read flags and row window
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job_in;
		end
		if (rd.en) begin
			rd_half_q <= rd_row[0];
			rd_zero_q <= job_q.is8 ? rd_row[3] : (rd_row >= 4'd4);
		end
		if (state_q == ST_LOAD) begin
			if (ld_q == 2'd1) begin
				win0_q <= fetched;
			end
			if (ld_q == 2'd2) begin
				win1_q <= fetched;
			end
			if (ld_q == 2'd3) begin
				win2_q <= fetched;
			end
		end else if (advance && row_end) begin
			win0_q <= win1_q;
			win1_q <= win2_q;
			win2_q <= fetched;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {7'd0, job_q.total, range_ctx, bctx, lv_self, position};
			out_last_q <= grid_end;
		end
	end

	assign done.valid = advance && grid_end;
	assign done.bank  = job_q.bank;
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tlast    = out_last_q;

endmodule

// File: rtl/core/coeff_level_context_derive.sv
// Top level of the coefficient level context block.
// Instantiates clc_front, clc_store, clc_job_fifo and clc_back; depends on clc_pkg.
//
// Coefficients enter one per cycle in raster order (16 for a 4x4 grid, 64 for the
// top-left 8x8 corner). After the last one, a result per position leaves in raster
// order, one per cycle while m_tready is high, after the row window is preloaded
// with three rows from the level store's single read port. The store has two banks,
// so a new grid loads while the previous one is emitted; input stalls only while both
// banks hold grids not yet emitted. The level store needs no clearing after reset.
// block_size must be written only while no grid is in flight; the block itself does
// not enforce this.
module coeff_level_context_derive import clc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [1:0]        cfg_wdata,   // block_size
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [COEF_W-1:0] s_tdata,     // [15:0] coefficient
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,     // [5:0] position, [9:6] level,
	                                       // [13:10] base_context, [18:14] range_context,
	                                       // [24:19] total_level, [31:25] zero
	output logic              m_tlast      // last_of_block
);

	wr_req_t          wr;
	rd_req_t          rd;
	logic [ROW_W-1:0] rdata;
	logic             push;
	job_t             push_job;
	logic             pop;
	job_t             pop_job;
	logic             job_ready;
	done_t            done;

	clc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.wr       (wr),
		.push     (push),
		.push_job (push_job),
		.done     (done)
	);

	clc_store u_store (
		.clk  (clk),
		.wr   (wr),
		.rd   (rd),
		.rdata(rdata)
	);

	clc_job_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.not_empty(job_ready)
	);

	clc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_ready(job_ready),
		.job_in   (pop_job),
		.pop      (pop),
		.rd       (rd),
		.rdata    (rdata),
		.done     (done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: rtl/core/clc_checker.sv
// Port-level checks for coeff_level_context_derive, bound to the top level.
// Depends on clc_pkg.
module clc_checker import clc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_W-1:0]  m_tdata,
	input logic              m_tlast
);

	// Hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// Drop output valid during reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// Close a grid only at its final position
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[5:0] == 6'd15) || (m_tdata[5:0] == 6'd63))
		else $error("last flag on wrong position");

	// Keep origin contexts free of offsets
	a_origin_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5:0] == 6'd0) |-> (m_tdata[13:10] <= 4'd4)
		&& (m_tdata[18:14] <= 5'd6) && !m_tlast)
		else $error("origin context out of range");

endmodule

bind coeff_level_context_derive clc_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

// File: tb/sv/tb_top.sv
// Testbench for coeff_level_context_derive: streams coefficient grids in and
// checks every context result against an in-bench model of the level store.
// Depends on clc_pkg and the RTL of the block; needs nothing else.
module tb_top;
	import clc_pkg::*;

	localparam int PRINT_LIMIT  = 60;
	localparam int SETTLE_WAIT  = 80;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int LONG_HOLD    = 300;

	// Idle patterns for either side of the stream
	typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_DENSE} idle_mode_t;

	// Grid side codes of block_size
	localparam logic [1:0] SIZE_4X4   = 2'd0;
	localparam logic [1:0] SIZE_8X8   = 2'd1;

	typedef struct {
		logic [5:0] position;
		logic [3:0] level;
		logic [3:0] bctx;
		logic [4:0] range_ctx;
		logic [5:0] total;
		logic       last;
	} ctx_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wen;
	logic [1:0]        cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [COEF_W-1:0] s_tdata;     // [15:0] coefficient
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;     // [5:0] position, [9:6] level, [13:10] base_context,
	                                // [18:14] range_context, [24:19] total_level, [31:25] zero
	logic              m_tlast;     // last_of_block

	// Model state of the block
	logic [3:0]   grid_levels [64];
	int           load_count;
	int           level_sum;
	logic [1:0]   size_code;
	ctx_result_t  expected_contexts [$];

	int           mismatch_count;
	idle_mode_t   src_mode;
	idle_mode_t   sink_mode;
	int           sink_idle_left;
	int           sink_hold_cycles;

	coeff_level_context_derive dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	function automatic int pick_gap(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:   return 0;
			IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
			default:     return $urandom_range(0, 19);
		endcase
	endfunction

	// Mostly small levels so the neighbor caps matter; some clamp and full-range values
	function automatic logic [15:0] rand_coefficient(input bit sparse);
		int sel;
		int v;
		sel = $urandom_range(0, 9);
		if (sparse && sel < 7)
			return 16'd0;
		case (sel)
			0, 1, 2: v = $urandom_range(0, 6);
			3, 4, 5: v = $urandom_range(0, 20);
			6, 7:    v = $urandom_range(100, 140);
			default: return 16'($urandom());
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v[15:0];
	endfunction

	function automatic int level_near(input int r, input int c, input int side);
		if (r >= side || c >= side)
			return 0;
		return grid_levels[(r * side + c) & 63];
	endfunction

	function automatic int cap3(input int v);
		return (v > 3) ? 3 : v;
	endfunction

	function automatic int half_capped(input int s, input int cap);
		int h;
		h = (s + 1) >> 1;
		return (h > cap) ? cap : h;
	endfunction

	// Store the level of one coefficient; on a full grid queue all its results
	task automatic absorb_coefficient(input logic [15:0] raw);
		int mag;
		int side;
		int bsum;
		int rsum;
		int boff;
		int roff;
		int d;
		ctx_result_t res;
		if (raw[15]) begin
			mag = 65536 - int'(raw);
			if (mag > 128)
				mag = 128;
		end else begin
			mag = int'(raw);
			if (mag > 127)
				mag = 127;
		end
		grid_levels[load_count & 63] = (mag > 15) ? 4'd15 : mag[3:0];
		level_sum = (level_sum + mag > 63) ? 63 : level_sum + mag;
		load_count = (load_count + 1) & 127;
		side = (size_code == SIZE_4X4) ? 4 : 8;
		if (load_count >= side * side) begin
			for (int r = 0; r < side; r++) begin
				for (int c = 0; c < side; c++) begin
					d = r + c;
					bsum = cap3(level_near(r, c + 1, side)) + cap3(level_near(r + 1, c, side))
					     + cap3(level_near(r + 1, c + 1, side))
					     + cap3(level_near(r, c + 2, side)) + cap3(level_near(r + 2, c, side));
					rsum = level_near(r, c + 1, side) + level_near(r + 1, c, side)
					     + level_near(r + 1, c + 1, side);
					boff = (d == 0) ? 0 : (d < 2) ? 1 : (d < 4) ? 6 : 11;
					roff = (d == 0) ? 0 : (r < 2 && c < 2) ? 7 : 14;
					res.position  = 6'(r * side + c);
					res.level     = 4'(level_near(r, c, side));
					res.bctx      = 4'(half_capped(bsum, 4) + boff);
					res.range_ctx = 5'(half_capped(rsum, 6) + roff);
					res.total     = 6'(level_sum);
					res.last      = (r == side - 1) && (c == side - 1);
					expected_contexts.push_back(res);
				end
			end
			load_count = 0;
			level_sum  = 0;
		end
	endtask

	// Offer one coefficient after an idle gap; hold until the request is taken
	task automatic send_coefficient(input logic [15:0] coef, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= coef;
		do @(posedge clk); while (!s_tready);
		absorb_coefficient(coef);
	endtask

	task automatic send_random(input int count, input bit sparse);
		for (int i = 0; i < count; i++)
			send_coefficient(rand_coefficient(sparse), pick_gap(src_mode));
	endtask

	// Drop the request and wait for every pending result
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (expected_contexts.size() == 0);
	endtask

	task automatic set_block_size(input logic [1:0] code);
		wait_drained();
		repeat (SETTLE_WAIT) @(posedge clk);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= code;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		size_code  = code;
	endtask

	// Clamp extremes, cap edges and sum saturation in one 4x4 grid
	task automatic test_corner_values();
		logic [15:0] vals [16];
		vals = '{16'sd0, 16'sd1, -16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd15, 16'sd16,
		         -16'sd15, -16'sd16, 16'sd127, 16'sd128, -16'sd128, -16'sd129,
		         16'sd32767, 16'h8000};
		set_block_size(SIZE_4X4);
		src_mode  = IDLE_DENSE;
		sink_mode = IDLE_SPARSE;
		foreach (vals[i])
			send_coefficient(vals[i], pick_gap(src_mode));
	endtask

	task automatic test_large_grid(input logic [1:0] code, input bit sparse);
		set_block_size(code);
		src_mode  = IDLE_SPARSE;
		sink_mode = sparse ? IDLE_DENSE : IDLE_SPARSE;
		send_random(64, sparse);
	endtask

	// Stall the output long enough that both banks fill and the input stalls
	task automatic test_output_backpressure();
		set_block_size(SIZE_4X4);
		src_mode  = IDLE_NONE;
		sink_mode = IDLE_NONE;
		sink_hold_cycles = LONG_HOLD;
		send_random(16, 1'b0);
		send_random(16, 1'b1);
		send_random(16, 1'b0);
	endtask

	// Pause with half a grid loaded until the previous grid has drained
	task automatic test_pause_mid_grid();
		src_mode  = IDLE_SPARSE;
		sink_mode = IDLE_DENSE;
		send_random(24, 1'b0);
		wait_drained();
		src_mode = IDLE_DENSE;
		send_random(8, 1'b1);
	endtask

	// Receiver: hold off for a requested stretch, else idle the drawn gap
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_cycles > 0) begin
				m_tready <= 1'b0;
				sink_hold_cycles--;
			end else if (sink_idle_left > 0) begin
				m_tready <= 1'b0;
				sink_idle_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest pending one
	always @(posedge clk) begin : check_results
		ctx_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			sink_idle_left = pick_gap(sink_mode);
			if (expected_contexts.size() == 0) begin
				report_mismatch($sformatf("unexpected result, tdata %h", m_tdata));
			end else begin
				want = expected_contexts.pop_front();
				check_field("position", m_tdata[5:0], want.position);
				check_field("level", m_tdata[9:6], want.level);
				check_field("base_context", m_tdata[13:10], want.bctx);
				check_field("range_context", m_tdata[18:14], want.range_ctx);
				check_field("total_level", m_tdata[24:19], want.total);
				check_field("tdata padding", m_tdata[31:25], 0);
				check_field("last_of_block", m_tlast, want.last);
			end
		end
	end

	initial begin
		#3_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		cfg_wen          = 1'b0;
		cfg_wdata        = SIZE_4X4;
		s_tvalid         = 1'b0;
		s_tdata          = '0;
		load_count       = 0;
		level_sum        = 0;
		size_code        = SIZE_4X4;
		mismatch_count   = 0;
		src_mode         = IDLE_NONE;
		sink_mode        = IDLE_NONE;
		sink_idle_left   = 0;
		sink_hold_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_corner_values();
		test_output_backpressure();
		test_pause_mid_grid();
		test_large_grid(SIZE_8X8, 1'b1);

		// Let the last grid drain, then give the block time to go quiet
		@(negedge clk);
		s_tvalid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && expected_contexts.size() != 0; i++)
			@(posedge clk);
		if (expected_contexts.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_contexts.size()));
		repeat (SETTLE_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
